// ===== sv/assert_macros.svh =====
// Assertion macros used by the regulator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HVD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define HVD_NEVER(lbl, clk, rst_n, cond, msg) \
  `HVD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== sv/hvdsr_pkg.sv =====
// Types, constants and helpers for the high-voltage duty step regulator.
package hvdsr_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int DUTY_BITS   = 11;
  localparam int TARGET_BITS = 9;
  localparam int DBAND_BITS  = 6;
  localparam int COUNT_BITS  = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [TARGET_BITS-1:0] TARGET_MIN = 9'd200;
  localparam logic [TARGET_BITS-1:0] TARGET_MAX = 9'd404;
  localparam logic [DUTY_BITS-1:0]   DUTY_LIMIT = 11'd1999;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = 8'd255;

  localparam logic [TARGET_BITS-1:0] RST_TARGET   = 9'd386;
  localparam logic [DBAND_BITS-1:0]  RST_DEADBAND = 6'd8;
  localparam logic [SAMPLE_BITS-1:0] RST_OV_LEVEL = 10'd405;
  localparam logic [SAMPLE_BITS-1:0] RST_RECOVER  = 10'd376;
  localparam logic [DUTY_BITS-1:0]   RST_CEILING  = 11'd400;
  localparam logic [DUTY_BITS-1:0]   RST_START    = 11'd20;
  localparam logic [COUNT_BITS-1:0]  RST_FAIL_TICKS = 8'd20;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OV_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_START      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAIL_TICKS = 3'd6;

  // Item opcodes.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ENABLE = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   enable_value;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 enabled;
    logic                 overvoltage;
    logic                 failed;
    logic                 regulating;
  } out_item_t;

  typedef struct packed {
    logic [TARGET_BITS-1:0] target_level;
    logic [DBAND_BITS-1:0]  deadband;
    logic [SAMPLE_BITS-1:0] overvoltage_level;
    logic [SAMPLE_BITS-1:0] recover_level;
    logic [DUTY_BITS-1:0]   duty_ceiling;
    logic [DUTY_BITS-1:0]   duty_start;
    logic [COUNT_BITS-1:0]  fail_ticks;
  } cfg_t;

  // Clamp a candidate duty (one bit of headroom) to the ceiling.
  function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic [DUTY_BITS:0] d,
                                                      input logic [DUTY_BITS-1:0] ceil);
    logic [DUTY_BITS:0] c;
    c = {1'b0, ceil};
    if (d > c) begin
      return ceil;
    end
    return d[DUTY_BITS-1:0];
  endfunction

endpackage

// ===== sv/hv_duty_step_regulator.sv =====
// Top level of the high-voltage PWM duty step regulator.
// Each transfer in is either a control tick with a feedback sample or an enable
// request, and each produces exactly one result transfer: the duty after the item
// plus the enable, overvoltage, fail and regulating flags. An item lands in an
// input register; once the output register is free the state update (one
// compare-and-step pass) runs and the result is captured in the output register,
// where it is offered until it moves on. One item per cycle is sustained while
// the output does not stall; the input register refills while a result waits,
// and only the state update of one item per cycle sets that figure.
// Configuration writes are taken on every cycle (ready is always high) and are
// expected while no item is in flight.
`include "assert_macros.svh"

module hv_duty_step_regulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hvdsr_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hvdsr_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hvdsr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [hvdsr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  hvdsr_pkg::cfg_t      cfg;
  hvdsr_pkg::in_item_t  in_q;
  hvdsr_pkg::out_item_t res_d, out_q;
  logic                 in_valid_q, out_valid_q;
  logic                 out_free, fire, in_take;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  // Process the held item when the output register can take its result.
  assign fire     = in_valid_q && out_free;
  // Input register is free when empty or its item moves on this cycle.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  hvdsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hvdsr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input register: hold while stalled, advance on a new transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Output register: load a fresh result, drop it once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HVD_ASSERT(a_hold_item, clk_i, rst_ni, (in_valid_q && !out_free) |=> in_valid_q, "held item lost")
  `HVD_ASSERT(a_duty_limit, clk_i, rst_ni, out_valid_q |-> (out_q.duty <= hvdsr_pkg::DUTY_LIMIT), "duty above limit")
  `HVD_NEVER(a_fault_enabled, clk_i, rst_ni, out_valid_q && !out_q.enabled && (out_q.overvoltage || out_q.failed), "fault latch while disabled")
  `HVD_ASSERT(a_reg_clean, clk_i, rst_ni, (out_valid_q && out_q.regulating) |-> (out_q.enabled && !out_q.overvoltage && !out_q.failed && out_q.duty != '0), "regulating flag inconsistent")

endmodule

// ===== sv/hvdsr_cfg.sv =====
// Configuration register file of the duty regulator, with write saturation.
module hvdsr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hvdsr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [hvdsr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output hvdsr_pkg::cfg_t                     cfg_o
);

  hvdsr_pkg::cfg_t cfg_q, cfg_d;
  logic [hvdsr_pkg::TARGET_BITS-1:0] tgt_raw;
  logic [hvdsr_pkg::DUTY_BITS-1:0]   duty_raw, duty_sat;

  assign cfg_ready_o = 1'b1;
  assign tgt_raw  = cfg_data_i[hvdsr_pkg::TARGET_BITS-1:0];
  assign duty_raw = cfg_data_i[hvdsr_pkg::DUTY_BITS-1:0];
  assign duty_sat = (duty_raw > hvdsr_pkg::DUTY_LIMIT) ? hvdsr_pkg::DUTY_LIMIT : duty_raw;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hvdsr_pkg::REG_SETPOINT: begin
          if (tgt_raw < hvdsr_pkg::TARGET_MIN) begin
            cfg_d.target_level = hvdsr_pkg::TARGET_MIN;
          end else if (tgt_raw > hvdsr_pkg::TARGET_MAX) begin
            cfg_d.target_level = hvdsr_pkg::TARGET_MAX;
          end else begin
            cfg_d.target_level = tgt_raw;
          end
        end
        hvdsr_pkg::REG_DEADBAND: begin
          cfg_d.deadband = cfg_data_i[hvdsr_pkg::DBAND_BITS-1:0];
        end
        hvdsr_pkg::REG_OV_LEVEL: begin
          cfg_d.overvoltage_level = cfg_data_i[hvdsr_pkg::SAMPLE_BITS-1:0];
        end
        hvdsr_pkg::REG_RECOVER: begin
          cfg_d.recover_level = cfg_data_i[hvdsr_pkg::SAMPLE_BITS-1:0];
        end
        hvdsr_pkg::REG_CEILING: begin
          cfg_d.duty_ceiling = duty_sat;
        end
        hvdsr_pkg::REG_START: begin
          cfg_d.duty_start = duty_sat;
        end
        hvdsr_pkg::REG_FAIL_TICKS: begin
          cfg_d.fail_ticks = cfg_data_i[hvdsr_pkg::COUNT_BITS-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level      <= hvdsr_pkg::RST_TARGET;
      cfg_q.deadband          <= hvdsr_pkg::RST_DEADBAND;
      cfg_q.overvoltage_level <= hvdsr_pkg::RST_OV_LEVEL;
      cfg_q.recover_level     <= hvdsr_pkg::RST_RECOVER;
      cfg_q.duty_ceiling      <= hvdsr_pkg::RST_CEILING;
      cfg_q.duty_start        <= hvdsr_pkg::RST_START;
      cfg_q.fail_ticks        <= hvdsr_pkg::RST_FAIL_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/hvdsr_core.sv =====
// Regulator state and its per-item update; presents the next result.
module hvdsr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  hvdsr_pkg::in_item_t  item_i,
  input  hvdsr_pkg::cfg_t      cfg_i,
  output hvdsr_pkg::out_item_t res_o
);

  localparam int SW = hvdsr_pkg::SAMPLE_BITS + 1;
  localparam int DW = hvdsr_pkg::DUTY_BITS;
  localparam int CW = hvdsr_pkg::COUNT_BITS;

  logic [DW-1:0] duty_q, duty_d;
  logic          en_q, en_d, ov_q, ov_d, fail_q, fail_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [hvdsr_pkg::SAMPLE_BITS-1:0] last_q, last_d;

  logic [SW-1:0] tgt_w, db_w, smp_w, last_w, band_hi;
  logic          sense_low, sense_high, reg_ok;

  assign tgt_w   = SW'(cfg_i.target_level);
  assign db_w    = SW'(cfg_i.deadband);
  assign smp_w   = SW'(item_i.sample);
  assign last_w  = SW'(last_d);
  assign band_hi = tgt_w + db_w;

  assign sense_low  = (smp_w + db_w) < tgt_w;
  assign sense_high = smp_w > band_hi;
  assign cnt_inc    = (cnt_q != hvdsr_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    duty_d = duty_q;
    en_d   = en_q;
    ov_d   = ov_q;
    fail_d = fail_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    unique case (item_i.opcode)
      hvdsr_pkg::OP_TICK: begin
        last_d = item_i.sample;
        if (!en_q || fail_q) begin
          duty_d = '0;
          cnt_d  = '0;
        end else if (item_i.sample >= cfg_i.overvoltage_level) begin
          ov_d   = 1'b1;
          duty_d = '0;
          cnt_d  = '0;
        end else if (ov_q) begin
          if (item_i.sample <= cfg_i.recover_level) begin
            ov_d   = 1'b0;
            duty_d = hvdsr_pkg::clamp_duty({1'b0, cfg_i.duty_start}, cfg_i.duty_ceiling);
          end
        end else if (sense_low) begin
          if (duty_q < cfg_i.duty_ceiling) begin
            duty_d = hvdsr_pkg::clamp_duty({1'b0, duty_q} + 1'b1, cfg_i.duty_ceiling);
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc >= cfg_i.fail_ticks) begin
              fail_d = 1'b1;
              duty_d = '0;
            end
          end
        end else begin
          cnt_d = '0;
          if (sense_high && duty_q != '0) begin
            duty_d = hvdsr_pkg::clamp_duty({1'b0, duty_q} - 1'b1, cfg_i.duty_ceiling);
          end
        end
      end
      hvdsr_pkg::OP_ENABLE: begin
        en_d = item_i.enable_value;
        if (!item_i.enable_value) begin
          ov_d   = 1'b0;
          fail_d = 1'b0;
          duty_d = '0;
        end else if (duty_q == '0) begin
          duty_d = hvdsr_pkg::clamp_duty({1'b0, cfg_i.duty_start}, cfg_i.duty_ceiling);
        end
      end
      default: begin
        duty_d = duty_q;
      end
    endcase
  end

  assign reg_ok = en_d && !ov_d && !fail_d && (duty_d != '0) &&
                  ((last_w + db_w) >= tgt_w) && (last_w <= band_hi);

  assign res_o.duty        = duty_d;
  assign res_o.enabled     = en_d;
  assign res_o.overvoltage = ov_d;
  assign res_o.failed      = fail_d;
  assign res_o.regulating  = reg_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      en_q   <= 1'b0;
      ov_q   <= 1'b0;
      fail_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
    end else if (fire_i) begin
      duty_q <= duty_d;
      en_q   <= en_d;
      ov_q   <= ov_d;
      fail_q <= fail_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

endmodule
